/* src/mit_pkg.sv */
package mit_pkg;

	typedef enum logic [1:0] {
		REG_MOTION_LIMIT       = 2'd0,
		REG_LOST_THRESHOLD     = 2'd1,
		REG_REPORT_INTERVAL    = 2'd2,
		REG_SECONDS_PER_REPORT = 2'd3
	} reg_index_t;

	localparam logic [15:0] MOTION_LIMIT_RESET       = 16'd1200;
	localparam logic [15:0] LOST_THRESHOLD_RESET     = 16'd600;
	localparam logic [15:0] REPORT_INTERVAL_RESET    = 16'd100;
	localparam logic [7:0]  SECONDS_PER_REPORT_RESET = 8'd10;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_item_t;

	typedef struct packed {
		logic        moving;
		logic        lost_active;
		logic        entered_lost;
		logic        left_lost;
		logic        report_due;
		logic [31:0] seconds_lost;
	} out_item_t;

	typedef struct packed {
		logic [15:0] motion_limit;
		logic [15:0] lost_threshold;
		logic [15:0] report_interval;
		logic [7:0]  seconds_per_report;
	} cfg_t;

	typedef struct packed {
		logic [15:0] prev_x;
		logic [15:0] prev_y;
		logic [15:0] prev_z;
		logic        reference_loaded;
		logic [15:0] still_count;
		logic        lost_flag;
		logic [15:0] interval_count;
		logic [31:0] lost_time;
	} track_state_t;

endpackage

/* src/mit_if.sv */
interface mit_in_if
	import mit_pkg::*;
();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mit_out_if
	import mit_pkg::*;
();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/mit_cfg.sv */
module mit_cfg
	import mit_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motion_limit       <= MOTION_LIMIT_RESET;
			cfg_q.lost_threshold     <= LOST_THRESHOLD_RESET;
			cfg_q.report_interval    <= REPORT_INTERVAL_RESET;
			cfg_q.seconds_per_report <= SECONDS_PER_REPORT_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_addr))
				REG_MOTION_LIMIT:       cfg_q.motion_limit       <= cfg_wdata;
				REG_LOST_THRESHOLD:     cfg_q.lost_threshold     <= cfg_wdata;
				REG_REPORT_INTERVAL:    cfg_q.report_interval    <= cfg_wdata;
				REG_SECONDS_PER_REPORT: cfg_q.seconds_per_report <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/mit_step.sv */
module mit_step
	import mit_pkg::*;
(
	input  cfg_t         cfg,
	input  track_state_t st,
	input  in_item_t     sample,
	output track_state_t st_next,
	output out_item_t    res
);

	function automatic logic [16:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
		logic signed [16:0] d;
		begin
			d = {a[15], a} - {b[15], b};
			abs_diff = d[16] ? 17'(-d) : 17'(d);
		end
	endfunction

	logic        still;
	logic [15:0] lthr;
	logic [15:0] rint;
	logic [32:0] sum;

	always_comb begin
		st_next = st;
		res     = '0;
		sum     = '0;
		lthr    = (cfg.lost_threshold == 16'd0) ? 16'd1 : cfg.lost_threshold;
		rint    = (cfg.report_interval == 16'd0) ? 16'd1 : cfg.report_interval;
		still   = (abs_diff(sample.accel_x, st.prev_x) < {1'b0, cfg.motion_limit})
			&& (abs_diff(sample.accel_y, st.prev_y) < {1'b0, cfg.motion_limit})
			&& (abs_diff(sample.accel_z, st.prev_z) < {1'b0, cfg.motion_limit});

		if (st.reference_loaded) begin
			if (still) begin
				if (st.still_count != COUNT_MAX)
					st_next.still_count = st.still_count + 16'd1;
			end else begin
				res.moving          = 1'b1;
				st_next.still_count = '0;
				if (st.lost_flag) begin
					st_next.lost_flag      = 1'b0;
					st_next.interval_count = '0;
					st_next.lost_time      = '0;
					res.left_lost          = 1'b1;
				end
			end
			if (st_next.still_count >= lthr && !st_next.lost_flag) begin
				st_next.lost_flag = 1'b1;
				res.entered_lost  = 1'b1;
			end
			if (st_next.lost_flag) begin
				if (st_next.interval_count != COUNT_MAX)
					st_next.interval_count = st_next.interval_count + 16'd1;
				if (st_next.interval_count >= rint) begin
					sum = {1'b0, st_next.lost_time} + {25'd0, cfg.seconds_per_report};
					st_next.lost_time      = sum[32] ? TIME_MAX : sum[31:0];
					st_next.interval_count = '0;
					res.report_due         = 1'b1;
					res.seconds_lost       = st_next.lost_time;
				end
			end
		end
		res.lost_active          = st_next.lost_flag;
		st_next.reference_loaded = 1'b1;
		st_next.prev_x           = sample.accel_x;
		st_next.prev_y           = sample.accel_y;
		st_next.prev_z           = sample.accel_z;
	end

endmodule

/* src/motion_inactivity_lost_tracker.sv */
// Motion inactivity / lost tracker.
// sample: one three-axis accelerometer item per handshake (valid/ready).
// result: one status item per sample: moving, lost_active, entered_lost,
//   left_lost, report_due and seconds_lost (nonzero only with report_due).
// cfg_we/cfg_addr/cfg_wdata: register writes, taken at any edge with
//   cfg_we high; write only while no item is in flight.
// Path: an accepted sample is captured in the input register, then the
//   tracker update writes its result into the result register.
// Throughput: one item per cycle while result.ready stays high; the tracker
//   state update is combinational compare and increment logic, so
//   consecutive samples follow back to back.
// Stall: while the result is not taken, one more sample is held in the
//   input register; then ready drops until the result drains.
// Reset: clears the tracker state and loads register defaults; the first
//   sample after reset only loads the reference and yields an all-zero
//   result.
module motion_inactivity_lost_tracker
	import mit_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mit_in_if.sink      sample,
	mit_out_if.source   result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	cfg_t         cfg;
	track_state_t state_q;
	track_state_t state_next;
	out_item_t    res_next;

	logic         valid_s1;
	in_item_t     item_s1;
	logic         out_valid_q;
	out_item_t    out_q;
	logic         advance;

	mit_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mit_step u_step (
		.cfg     (cfg),
		.st      (state_q),
		.sample  (item_s1),
		.st_next (state_next),
		.res     (res_next)
	);

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q     <= state_next;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready)
			item_s1 <= sample.data;
		if (advance)
			out_q <= res_next;
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && !advance && sample.valid && sample.ready))
		else $error("input item accepted over a held item");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.valid)
		else $error("result missing after advance");

	a_entered_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.entered_lost) |-> result.data.lost_active)
		else $error("entered lost without lost flag");

	a_left_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.left_lost)
			|-> (result.data.moving && !result.data.lost_active))
		else $error("left lost without movement");

endmodule
